>>> sv/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and constants of the Goertzel tone power block.
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam int STATE_WIDTH  = 32;
	localparam int COEF_WIDTH   = 11;
	localparam int SAMPLE_WIDTH = 16;
	localparam int POWER_WIDTH  = 32;
	localparam int PROD_WIDTH   = 2 * STATE_WIDTH;
	localparam int CPROD_WIDTH  = COEF_WIDTH + STATE_WIDTH;
	localparam int PADDR_WIDTH  = 3;
	localparam int PDATA_WIDTH  = 32;

	// register index, taken from paddr[2]
	localparam logic REG_COEF = 1'b0;

	// action codes carried on tuser
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef struct packed {
		logic                           action;
		logic signed [SAMPLE_WIDTH-1:0] sample;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_word_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_REC,
		BK_UPD,
		BK_PW1,
		BK_PW2,
		BK_OUT
	} back_state_t;

endpackage

>>> sv/gtp_front.sv
// ----------------------------------------------------------------------------
// gtp_front
// Input side: accepts words and classifies them into a two-entry queue.
// ----------------------------------------------------------------------------
module gtp_front
	import gtp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [SAMPLE_WIDTH-1:0] s_tdata,  // [15:0] sample
	input  logic                    s_tuser,  // [0] action
	output q_word_t                 q_word,
	input  logic                    q_take
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      in_item;

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_take && (count_q != 2'd0);

	always_comb begin
		in_item.action = (s_tuser == ACT_CLEAR) ? ACT_CLEAR : ACT_SAMPLE;
		// sample is don't-care on clear; zero it so the back end sees a clean word
		in_item.sample = (s_tuser == ACT_CLEAR) ? '0 : $signed(s_tdata);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign q_word.valid = (count_q != 2'd0);
	assign q_word.item  = entry_q[rd_ptr_q];

endmodule

>>> sv/gtp_back.sv
// ----------------------------------------------------------------------------
// gtp_back
// Execution side: runs the recurrence and the power products, holds the result.
// ----------------------------------------------------------------------------
module gtp_back
	import gtp_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  q_word_t                       q_word,
	output logic                          q_take,
	input  logic signed [COEF_WIDTH-1:0]  coef,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [POWER_WIDTH-1:0]        m_tdata   // [31:0] power
);

	back_state_t state_q, state_d;

	item_t                          item_q;
	logic signed [STATE_WIDTH-1:0]  d1_q;
	logic signed [STATE_WIDTH-1:0]  d2_q;
	logic signed [CPROD_WIDTH-1:0]  rec_s1;
	logic signed [PROD_WIDTH-1:0]   pd1_s1;
	logic signed [PROD_WIDTH-1:0]   pd2_s1;
	logic signed [CPROD_WIDTH-1:0]  pc_s1;
	logic signed [PROD_WIDTH-1:0]   p3_s2;
	logic [POWER_WIDTH-1:0]         out_q;
	logic                           out_valid_q;
	logic                           out_load;
	logic signed [STATE_WIDTH-1:0]  sample_ext;
	logic signed [STATE_WIDTH-1:0]  s0;
	logic signed [STATE_WIDTH-1:0]  pc_fix;
	logic signed [STATE_WIDTH-1:0]  power;

	// product at 64 bits, arithmetic shift, keep the state width
	function automatic logic [STATE_WIDTH-1:0] fix64(input logic signed [PROD_WIDTH-1:0] p);
		logic signed [PROD_WIDTH-1:0] sh;
		sh = p >>> FRAC_BITS;
		return sh[STATE_WIDTH-1:0];
	endfunction

	function automatic logic [STATE_WIDTH-1:0] fixc(input logic signed [CPROD_WIDTH-1:0] p);
		logic signed [PROD_WIDTH-1:0] ext;
		ext = {{(PROD_WIDTH-CPROD_WIDTH){p[CPROD_WIDTH-1]}}, p};
		return fix64(ext);
	endfunction

	assign sample_ext = {{(STATE_WIDTH-SAMPLE_WIDTH){item_q.sample[SAMPLE_WIDTH-1]}},
		item_q.sample};
	assign s0     = sample_ext + $signed(fixc(rec_s1)) - d2_q;
	assign pc_fix = $signed(fixc(pc_s1));
	assign power  = $signed(fix64(pd1_s1)) + $signed(fix64(pd2_s1)) - $signed(fix64(p3_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_take   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_word.valid) begin
					q_take  = 1'b1;
					state_d = BK_REC;
				end
			end
			BK_REC: begin
				state_d = (item_q.action == ACT_CLEAR) ? BK_PW1 : BK_UPD;
			end
			BK_UPD: begin
				state_d = BK_PW1;
			end
			BK_PW1: begin
				state_d = BK_PW2;
			end
			BK_PW2: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				// wait for the output slot, then pick up the next word at once
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					if (q_word.valid) begin
						q_take  = 1'b1;
						state_d = BK_REC;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q        <= '0;
			d2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_REC && item_q.action == ACT_CLEAR) begin
				d1_q <= '0;
				d2_q <= '0;
			end else if (state_q == BK_UPD) begin
				d2_q <= d1_q;
				d1_q <= s0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			item_q <= q_word.item;
		end
		if (state_q == BK_REC) begin
			rec_s1 <= coef * d1_q;
		end
		if (state_q == BK_PW1) begin
			pd1_s1 <= d1_q * d1_q;
			pd2_s1 <= d2_q * d2_q;
			pc_s1  <= coef * d1_q;
		end
		if (state_q == BK_PW2) begin
			p3_s2 <= pc_fix * d2_q;
		end
		if (out_load) begin
			out_q <= power[POWER_WIDTH-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> sv/goertzel_tone_power.sv
// ----------------------------------------------------------------------------
// goertzel_tone_power
// Fixed-point Goertzel filter reporting tone power after every word.
// ----------------------------------------------------------------------------
// Each input word either feeds a sample into the two-word Goertzel state or
// clears it, and yields one power word computed from the updated state. A
// two-entry queue takes input words while the back end works; the back end
// runs a sequencer over registered multiplier stages: recurrence product,
// state update, three parallel power products, coefficient-weighted cross
// product, final sum; a clear word skips the update. Back-to-back words follow
// with no idle state while results are taken. The coefficient register sits at
// byte address 0; the user must write it only while idle (not enforced).
module goertzel_tone_power
	import gtp_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [SAMPLE_WIDTH-1:0] s_tdata,  // [15:0] sample
	input  logic                    s_tuser,  // [0] action
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [POWER_WIDTH-1:0]  m_tdata,  // [31:0] power
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_WIDTH-1:0]  paddr,
	input  logic [PDATA_WIDTH-1:0]  pwdata,
	output logic [PDATA_WIDTH-1:0]  prdata,
	output logic                    pready
);

	logic signed [COEF_WIDTH-1:0] coef_q;
	logic                         reg_idx;
	logic                         cfg_wr;
	q_word_t                      q_word;
	logic                         q_take;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_WIDTH-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_wr && reg_idx == REG_COEF) begin
			coef_q <= $signed(pwdata[COEF_WIDTH-1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_COEF) begin
			prdata = {{(PDATA_WIDTH-COEF_WIDTH){coef_q[COEF_WIDTH-1]}}, coef_q};
		end
	end

	gtp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_word   (q_word),
		.q_take   (q_take)
	);

	gtp_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_word   (q_word),
		.q_take   (q_take),
		.coef     (coef_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a full queue must always present work to the back end
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_word.valid)
		else $error("queue full but head not valid");

	// back end pops only a valid head
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_word.valid)
		else $error("pop from empty queue");

	// a coefficient write lands in the register
	a_coef_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == REG_COEF) |=> coef_q == $past(pwdata[COEF_WIDTH-1:0]))
		else $error("coefficient write lost");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the Goertzel tone power block.
// ----------------------------------------------------------------------------
// Words go in through a bursty stream driver. A predictor of its own tracks the
// two delay words and the coefficient and works out the power for every
// accepted word. A monitor checks each power word against the oldest
// prediction. The coefficient is rewritten over APB between phases while the
// block is idle. The run covers a directed set of extremes, then random
// sample runs closed by clears, bar the last of each phase. The receiver
// stalls on a pattern of its own, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
	import gtp_pkg::*;

	localparam int FRAC_BITS   = 8;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 400;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [SAMPLE_WIDTH-1:0] s_tdata  = '0;
	logic                    s_tuser  = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [POWER_WIDTH-1:0]  m_tdata;
	logic                    psel     = 1'b0;
	logic                    penable  = 1'b0;
	logic                    pwrite   = 1'b0;
	logic [PADDR_WIDTH-1:0]  paddr    = '0;
	logic [PDATA_WIDTH-1:0]  pwdata   = '0;
	logic [PDATA_WIDTH-1:0]  prdata;
	logic                    pready;

	goertzel_tone_power #(
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [COEF_WIDTH-1:0]  coef_now  = '0;
	logic signed [STATE_WIDTH-1:0] delay_one = '0;
	logic signed [STATE_WIDTH-1:0] delay_two = '0;

	item_t                  word_queue[$];
	logic [POWER_WIDTH-1:0] power_expected[$];
	int                     fail_count  = 0;
	int                     cycle_count = 0;

	// product at 64 bits, arithmetic shift, truncate to the state width
	function automatic logic signed [STATE_WIDTH-1:0] fix_mul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] prod;
		prod = a * b;
		prod = prod >>> FRAC_BITS;
		return prod[STATE_WIDTH-1:0];
	endfunction

	function automatic logic [POWER_WIDTH-1:0] goertzel_step(input item_t w);
		logic signed [STATE_WIDTH-1:0] s0;
		logic signed [STATE_WIDTH-1:0] t1;
		logic signed [STATE_WIDTH-1:0] t2;
		logic signed [STATE_WIDTH-1:0] t3;
		if (w.action == ACT_CLEAR) begin
			delay_one = '0;
			delay_two = '0;
		end else begin
			s0 = STATE_WIDTH'($signed(w.sample)) + fix_mul(coef_now, delay_one) - delay_two;
			delay_two = delay_one;
			delay_one = s0;
		end
		t1 = fix_mul(delay_one, delay_one);
		t2 = fix_mul(delay_two, delay_two);
		t3 = fix_mul(fix_mul(coef_now, delay_one), delay_two);
		return POWER_WIDTH'(t1 + t2 - t3);
	endfunction

	// sender: bursts of random length with random gaps
	item_t tx_word;
	int    burst_left;
	int    gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (word_queue.size() != 0) begin
				tx_word = word_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= tx_word.sample;
				s_tuser  <= tx_word.action;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			power_expected.push_back(goertzel_step(item_t'{action: s_tuser, sample: s_tdata}));
	end

	// receiver: stall pattern re-picked each time the tick counter wraps, plus one long hold-off
	logic rx_long_req  = 1'b0;
	logic rx_long_done = 1'b0;
	int   rx_hold_left = 0;
	int   rx_tick      = 0;
	int   rx_mode      = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			rx_long_done <= 1'b0;
			rx_hold_left <= 0;
			rx_tick      <= 0;
			rx_mode      <= 0;
		end else begin
			if (rx_tick == 49) begin
				rx_tick <= 0;
				rx_mode <= $urandom_range(0, 3);
			end else begin
				rx_tick <= rx_tick + 1;
			end
			if (rx_long_req && !rx_long_done) begin
				rx_long_done <= 1'b1;
				rx_hold_left <= LONG_HOLD;
				m_tready     <= 1'b0;
			end else if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				m_tready     <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= rx_tick[2];
				endcase
			end
		end
	end

	// check each power word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (power_expected.size() == 0) begin
				$display("%0t: unexpected power word, expected none, got %0d", $time,
					$signed(m_tdata));
				fail_count++;
			end else begin
				if (m_tdata !== power_expected[0]) begin
					$display("%0t: power mismatch, expected %0d, got %0d", $time,
						$signed(power_expected[0]), $signed(m_tdata));
					fail_count++;
				end
				void'(power_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_coef(input int value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_COEF, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		coef_now = value[COEF_WIDTH-1:0];
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (word_queue.size() != 0 || s_tvalid || power_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_word(input logic action, input logic [SAMPLE_WIDTH-1:0] sample);
		word_queue.push_back(item_t'{action: action, sample: sample});
	endtask

	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3, 4: return SAMPLE_WIDTH'($urandom_range(0, 511) - 256);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	// sample runs of random length, closed by a clear bar the last; some stray clears
	task automatic random_phase(input int coef, input int count, input logic long_stall);
		int run_left;
		int pushed;
		write_coef(coef);
		if (long_stall)
			rx_long_req = 1'b1;
		run_left = $urandom_range(1, 60);
		pushed   = 0;
		while (pushed < count) begin
			if (run_left == 0 || $urandom_range(0, 49) == 0) begin
				push_word(ACT_CLEAR, SAMPLE_WIDTH'($urandom));
				run_left = $urandom_range(1, 60);
			end else begin
				push_word(ACT_SAMPLE, pick_sample());
				run_left--;
			end
			pushed++;
		end
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes at full resonance, clears with junk samples
		write_coef(512);
		repeat (4) push_word(ACT_SAMPLE, 16'h7fff);
		repeat (4) push_word(ACT_SAMPLE, 16'h8000);
		push_word(ACT_CLEAR, 16'h5555);
		push_word(ACT_SAMPLE, 16'h0000);
		push_word(ACT_SAMPLE, 16'hffff);
		push_word(ACT_SAMPLE, 16'h0001);
		push_word(ACT_SAMPLE, 16'h8000);
		push_word(ACT_SAMPLE, 16'h7fff);
		push_word(ACT_CLEAR, 16'hffff);
		push_word(ACT_CLEAR, 16'h0000);
		wait_idle();
		// coefficient beyond its nominal range, at the ends of the 11-bit signed field
		write_coef(-1024);
		repeat (3) push_word(ACT_SAMPLE, 16'h7fff);
		push_word(ACT_SAMPLE, 16'haaaa);
		wait_idle();
		write_coef(1023);
		repeat (3) push_word(ACT_SAMPLE, 16'h8000);
		push_word(ACT_CLEAR, 16'haaaa);
		wait_idle();

		random_phase(-512, 100, 1'b0);
		random_phase(0, 100, 1'b1);
		random_phase(362, 100, 1'b0);
		random_phase(1023, 100, 1'b0);
		random_phase(-1024, 100, 1'b0);
		random_phase(512, 100, 1'b0);
		repeat (3) random_phase($urandom_range(0, 1024) - 512, 100, 1'b0);
		random_phase($urandom_range(0, 2047) - 1024, 50, 1'b0);

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/gtp_pkg.sv
sv/gtp_front.sv
sv/gtp_back.sv
sv/goertzel_tone_power.sv
sim/tb_top.sv
